/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FOLI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FOLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/foli_pkg.sv */
// Shared types, codes and helpers of the first-order lag integrator.
package foli_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned MUL_W  = DATA_W + 1;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned RAD_W  = DATA_W + FRAC_W;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned CIDX_W = 3;

  // Mode bits
  localparam int unsigned MODE_EXT_FB = 0;
  localparam int unsigned MODE_SQ_IN  = 1;
  localparam int unsigned MODE_ROOT   = 2;

  // Operation codes carried in tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_STEP_COEF  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_GAIN       = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_OUT_MIN    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_OUT_MAX    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_INIT_VALUE = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_MODE       = 3'd5;

  // Register reset values
  localparam logic [COEF_W-1:0] RST_STEP_COEF = 16'd655;
  localparam logic [DATA_W-1:0] RST_GAIN      = 32'h0001_0000;
  localparam logic [DATA_W-1:0] RST_OUT_MIN   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] RST_OUT_MAX   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic                    go;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } foli_mul_req_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] res;
  } foli_mul_rsp_t;

  typedef struct packed {
    logic             go;
    logic [RAD_W-1:0] radicand;
  } foli_sqrt_req_t;

  typedef struct packed {
    logic              valid;
    logic [ROOT_W-1:0] root;
  } foli_sqrt_rsp_t;

  // Saturate a 33-bit sum or difference to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/foli_mul.sv */
// Shared signed multiplier: registered operands and product, floor shift by 16, saturation.
module foli_mul
  import foli_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  foli_mul_req_t req,
  output foli_mul_rsp_t rsp
);

  logic signed [MUL_W-1:0]  a_r;
  logic signed [MUL_W-1:0]  b_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     s1_r;
  logic                     valid_r;
  logic                     fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      s1_r <= req.go;
      if (req.go) begin
        valid_r <= 1'b0;
      end else if (s1_r) begin
        valid_r <= 1'b1;
      end
    end
    if (req.go) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (s1_r) begin
      prod_r <= a_r * b_r;
    end
  end

  // Arithmetic shift right by 16 is the floor; it fits 32 bits when the top bits agree.
  assign fits = (prod_r[PROD_W-1:FRAC_W+DATA_W-1] == '0) ||
                (prod_r[PROD_W-1:FRAC_W+DATA_W-1] == '1);

  always_comb begin
    rsp.valid = valid_r;
    if (fits) begin
      rsp.res = prod_r[FRAC_W+DATA_W-1:FRAC_W];
    end else if (prod_r[PROD_W-1]) begin
      rsp.res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      rsp.res = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

/* rtl/core/foli_sqrt.sv */
// Restoring integer square root, one result bit per cycle.
module foli_sqrt
  import foli_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  foli_sqrt_req_t req,
  output foli_sqrt_rsp_t rsp
);

  localparam int unsigned REM_W = ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              valid_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else if (req.go) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else if (busy_r && (cnt_r == '0)) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b1;
    end
    if (req.go) begin
      rad_r  <= req.radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CNT_W'(ROOT_W - 1);
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign rsp.valid = valid_r;
  assign rsp.root  = root_r;

endmodule

/* rtl/core/first_order_lag_integrator_unit.sv */
// First-order lag integrator: config registers, step sequencer, shared multiplier and root unit.
// Step item: input square if set, gain, coefficient, root of a positive state in root mode,
//   clamp, output square (three to four two-stage multiplier passes, 24-step square root).
// Start item: no result; state loaded (squared in root mode), then idle for the next beat.
// One item at a time; next beat taken the cycle after a result registers, even if it waits.
// Reset (rst_n, synchronous): integrator cleared, registers to defaults, no result pending.
module first_order_lag_integrator_unit
  import foli_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input beats
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [95:0]       in_tdata,   // drive_in[31:0], noise_in[63:32], feedback_in[95:64]
  input  logic              in_tuser,   // operation[0]
  // result beats
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // value[31:0], value_squared[62:32], zero[63]
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_USQ, S_GAIN, S_COEF, S_ROOT, S_CLAMP, S_OUTSQ
  } state_t;

  state_t                   state_r;
  logic                     issued_r;

  // configuration registers
  logic [COEF_W-1:0]        step_coef_r;
  logic signed [DATA_W-1:0] gain_r;
  logic signed [DATA_W-1:0] out_min_r;
  logic signed [DATA_W-1:0] out_max_r;
  logic signed [DATA_W-1:0] init_value_r;
  logic [MODE_W-1:0]        mode_r;

  // datapath
  logic signed [DATA_W-1:0] integ_r;
  logic signed [DATA_W-1:0] u_r;
  logic signed [DATA_W-1:0] fb_r;
  logic signed [DATA_W-1:0] diff_r;
  logic signed [DATA_W-1:0] v_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [DATA_W-2:0]        out_sq_r;

  foli_mul_req_t            mul_req;
  foli_mul_rsp_t            mul_rsp;
  foli_sqrt_req_t           sqrt_req;
  foli_sqrt_rsp_t           sqrt_rsp;

  logic                     in_fire;
  logic                     mul_done;
  logic signed [DATA_W-1:0] drive_in;
  logic signed [DATA_W-1:0] noise_in;
  logic signed [DATA_W-1:0] feedback_in;
  logic signed [DATA_W:0]   u_raw;
  logic signed [DATA_W-1:0] fb_sel;
  logic signed [DATA_W:0]   diff_raw;
  logic signed [DATA_W:0]   x_raw;
  logic signed [DATA_W-1:0] x_new;
  logic signed [DATA_W-1:0] v_hi;
  logic signed [DATA_W-1:0] v_clamped;
  logic [DATA_W-1:0]        mag;
  logic                     out_free;
  logic                     out_load;

  assign drive_in    = in_tdata[DATA_W-1:0];
  assign noise_in    = in_tdata[2*DATA_W-1:DATA_W];
  assign feedback_in = in_tdata[3*DATA_W-1:2*DATA_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign mul_done  = issued_r && mul_rsp.valid;
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == S_OUTSQ) && mul_done && out_free;

  // u = drive - noise, saturated
  assign u_raw = {drive_in[DATA_W-1], drive_in} - {noise_in[DATA_W-1], noise_in};

  // gain*u minus feedback, saturated
  assign fb_sel   = mode_r[MODE_EXT_FB] ? fb_r : integ_r;
  assign diff_raw = {mul_rsp.res[DATA_W-1], mul_rsp.res} - {fb_sel[DATA_W-1], fb_sel};

  // new state: integrator plus floor(coef*diff/2^16); the state itself is never clamped
  assign x_raw = {integ_r[DATA_W-1], integ_r} + {mul_rsp.res[DATA_W-1], mul_rsp.res};
  assign x_new = sat33(x_raw);

  // upper bound first, then lower: reversed bounds give out_min
  assign v_hi      = (v_r > out_max_r) ? out_max_r : v_r;
  assign v_clamped = (v_hi < out_min_r) ? out_min_r : v_hi;

  // magnitude of the clamped value; the most negative value maps to 2^31
  assign mag = v_r[DATA_W-1] ? (~v_r + 1'b1) : v_r;

  // Drive the shared multiplier once on entry of each multiply state.
  always_comb begin
    mul_req.go = 1'b0;
    mul_req.a  = '0;
    mul_req.b  = '0;
    unique case (state_r)
      S_INIT: begin
        mul_req.go = !issued_r && mode_r[MODE_ROOT];
        mul_req.a  = {init_value_r[DATA_W-1], init_value_r};
        mul_req.b  = {init_value_r[DATA_W-1], init_value_r};
      end
      S_USQ: begin
        mul_req.go = !issued_r;
        mul_req.a  = {u_r[DATA_W-1], u_r};
        mul_req.b  = {u_r[DATA_W-1], u_r};
      end
      S_GAIN: begin
        mul_req.go = !issued_r;
        mul_req.a  = {gain_r[DATA_W-1], gain_r};
        mul_req.b  = {u_r[DATA_W-1], u_r};
      end
      S_COEF: begin
        mul_req.go = !issued_r;
        mul_req.a  = {{(MUL_W-COEF_W){1'b0}}, step_coef_r};
        mul_req.b  = {diff_r[DATA_W-1], diff_r};
      end
      S_OUTSQ: begin
        mul_req.go = !issued_r;
        mul_req.a  = {1'b0, mag};
        mul_req.b  = {1'b0, mag};
      end
      default: begin
        mul_req.go = 1'b0;
      end
    endcase
  end

  // Start the root as soon as a positive new state is known.
  assign sqrt_req.go = (state_r == S_COEF) && mul_done && mode_r[MODE_ROOT] &&
                       (x_new > 0);
  assign sqrt_req.radicand = {x_new, {FRAC_W{1'b0}}};

  foli_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  foli_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issued_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      integ_r      <= '0;
      step_coef_r  <= RST_STEP_COEF;
      gain_r       <= RST_GAIN;
      out_min_r    <= RST_OUT_MIN;
      out_max_r    <= RST_OUT_MAX;
      init_value_r <= '0;
      mode_r       <= '0;
    end else begin
      // Take configuration writes; unknown indexes drop.
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_STEP_COEF:  step_coef_r  <= cfg_data[COEF_W-1:0];
          CFG_GAIN:       gain_r       <= cfg_data;
          CFG_OUT_MIN:    out_min_r    <= cfg_data;
          CFG_OUT_MAX:    out_max_r    <= cfg_data;
          CFG_INIT_VALUE: init_value_r <= cfg_data;
          CFG_MODE:       mode_r       <= cfg_data[MODE_W-1:0];
          default:        ;
        endcase
      end

      if (mul_req.go) begin
        issued_r <= 1'b1;
      end

      // Retire the pending result when the sink takes it and no new one lands.
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            u_r  <= sat33(u_raw);
            fb_r <= feedback_in;
            if (in_tuser == OP_START) begin
              state_r <= S_INIT;
            end else if (mode_r[MODE_SQ_IN]) begin
              state_r <= S_USQ;
            end else begin
              state_r <= S_GAIN;
            end
          end
        end
        S_INIT: begin
          if (!mode_r[MODE_ROOT]) begin
            integ_r <= init_value_r;
            state_r <= S_IDLE;
          end else if (mul_done) begin
            integ_r  <= mul_rsp.res;
            issued_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        S_USQ: begin
          if (mul_done) begin
            u_r      <= mul_rsp.res;
            issued_r <= 1'b0;
            state_r  <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (mul_done) begin
            diff_r   <= sat33(diff_raw);
            issued_r <= 1'b0;
            state_r  <= S_COEF;
          end
        end
        S_COEF: begin
          if (mul_done) begin
            integ_r  <= x_new;
            issued_r <= 1'b0;
            if (!mode_r[MODE_ROOT]) begin
              v_r     <= x_new;
              state_r <= S_CLAMP;
            end else if (x_new > 0) begin
              state_r <= S_ROOT;
            end else begin
              v_r     <= '0;
              state_r <= S_CLAMP;
            end
          end
        end
        S_ROOT: begin
          if (sqrt_rsp.valid) begin
            v_r     <= {{(DATA_W-ROOT_W){1'b0}}, sqrt_rsp.root};
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          v_r     <= v_clamped;
          state_r <= S_OUTSQ;
        end
        S_OUTSQ: begin
          // Hold the square in the multiplier until the output register frees up.
          if (out_load) begin
            out_value_r <= v_r;
            out_sq_r    <= mul_rsp.res[DATA_W-2:0];
            out_valid_r <= 1'b1;
            issued_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_sq_r, out_value_r};

endmodule

/* rtl/core/foli_checker.sv */
// Port-level checker for the first-order lag integrator, bound to the top level.
`include "assert_macros.svh"

module foli_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // a stalled result stays offered
  `FOLI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // one item at a time: busy right after any accepted beat
  `FOLI_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // a start beat never produces a result
  `FOLI_ASSERT_NEXT(a_start_silent, clk, rst_n, in_tvalid && in_tready && !in_tuser,
                    !$rose(out_tvalid))
  // a zero value has a zero square
  `FOLI_ASSERT_SAME(a_zero_square, clk, rst_n, out_tvalid && (out_tdata[31:0] == 32'd0),
                    out_tdata[62:32] == 31'd0)

endmodule

bind first_order_lag_integrator_unit foli_checker u_foli_checker (.*);
